// ----- src/tdc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tdc_pkg;
   localparam int DataWidth = 32;
   localparam int TypeWidth = 3;
   localparam int StatusWidth = 2;

   localparam logic [TypeWidth-1:0] TYPE_F32 = 3'd0;
   localparam logic [TypeWidth-1:0] TYPE_F16 = 3'd1;
   localparam logic [TypeWidth-1:0] TYPE_I32 = 3'd2;
   localparam logic [TypeWidth-1:0] TYPE_I16 = 3'd3;
   localparam logic [TypeWidth-1:0] TYPE_I8  = 3'd4;

   localparam logic [StatusWidth-1:0] STATUS_OK = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_UNSUPPORTED = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_SATURATED = 2'd2;

   localparam logic [0:0] CSR_SOURCE_TYPE = 1'd0;
   localparam logic [0:0] CSR_TARGET_TYPE = 1'd1;

   // operation picked in the first stage
   localparam logic [1:0] OP_COPY = 2'd0;
   localparam logic [1:0] OP_ERROR = 2'd1;
   localparam logic [1:0] OP_TO_F32 = 2'd2;
   localparam logic [1:0] OP_TO_INT = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [TypeWidth-1:0] dst;
   } ctrl_type;

   function automatic logic [31:0] width_mask(input logic [TypeWidth-1:0] t);
      case (t)
         TYPE_I8: width_mask = 32'h0000_00FF;
         TYPE_F16, TYPE_I16: width_mask = 32'h0000_FFFF;
         default: width_mask = 32'hFFFF_FFFF;
      endcase
   endfunction

   // leading one position of a 32 bit word, word assumed nonzero
   function automatic logic [4:0] lead_one(input logic [31:0] v);
      logic [4:0] p;
      p = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) p = 5'(i);
      end
      lead_one = p;
   endfunction
endpackage
`default_nettype wire

// ----- src/tdc_to_int.sv -----
`timescale 1ns / 1ps
`default_nettype none
// binary32 to integer, truncation toward zero with saturation, one register stage
module tdc_to_int (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  wire logic [31:0] in_f,
   input  wire logic [tdc_pkg::TypeWidth-1:0] in_dst,
   output logic out_valid,
   output logic [31:0] out_value,
   output logic [tdc_pkg::StatusWidth-1:0] out_status
);
   import tdc_pkg::*;

   logic valid_ff;
   logic [31:0] value_ff, value_in;
   logic [StatusWidth-1:0] status_ff, status_in;

   logic neg, nan, big;
   logic [7:0] ex;
   logic [23:0] sig;
   logic [31:0] mag, lim_pos, lim_neg, res;
   logic [7:0] k;

   always_comb begin
      neg = in_f[31];
      ex = in_f[30:23];
      sig = {1'b1, in_f[22:0]};
      nan = (ex == 8'hFF) && (in_f[22:0] != 23'd0);
      big = 1'b0;
      mag = 32'd0;
      k = ex - 8'd127;
      case (in_dst)
         TYPE_I8: begin lim_pos = 32'h7F; lim_neg = 32'h80; end
         TYPE_I16: begin lim_pos = 32'h7FFF; lim_neg = 32'h8000; end
         default: begin lim_pos = 32'h7FFF_FFFF; lim_neg = 32'h8000_0000; end
      endcase
      if (ex == 8'hFF) big = 1'b1;
      else if (ex < 8'd127) mag = 32'd0;
      else if (k <= 8'd23) mag = {8'd0, sig} >> (5'd23 - k[4:0]);
      else if (k <= 8'd31) mag = {8'd0, sig} << (k[4:0] - 5'd23);
      else big = 1'b1;
      status_in = STATUS_OK;
      if (nan) begin
         status_in = STATUS_SATURATED;
         mag = 32'd0;
      end else if (!neg && (big || mag > lim_pos)) begin
         status_in = STATUS_SATURATED;
         mag = lim_pos;
      end else if (neg && (big || mag > lim_neg)) begin
         status_in = STATUS_SATURATED;
         mag = lim_neg;
      end
      res = neg ? (32'd0 - mag) : mag;
      value_in = res & width_mask(in_dst);
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= in_valid;
      value_ff <= value_in;
      status_ff <= status_in;
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;
   assign out_status = status_ff;
endmodule
`default_nettype wire

// ----- src/tensor_dtype_converter_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   ports                                   handshake
// request   req_raw_element                         taken when start && !busy
// response  rsp_converted_element, rsp_status       rsp_valid for one cycle
// config    csr_write, csr_index, csr_data          taken when csr_write
//
// four register stages: decode/unpack, normalize, round, integer convert;
// one request per cycle; the response is registered by the integer convert stage.
// busy is never raised; the response side has no back pressure.
// synchronous reset clears the valid bits and the type registers.
module tensor_dtype_converter_core (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic [31:0] req_raw_element,
   output logic rsp_valid,
   output logic [31:0] rsp_converted_element,
   output logic [tdc_pkg::StatusWidth-1:0] rsp_status,
   input  wire logic csr_write,
   input  wire logic [0:0] csr_index,
   input  wire logic [tdc_pkg::TypeWidth-1:0] csr_data
);
   import tdc_pkg::*;

   logic [TypeWidth-1:0] src_ff, dst_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= TYPE_F32;
         dst_ff <= TYPE_F32;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SOURCE_TYPE: src_ff <= csr_data;
            CSR_TARGET_TYPE: dst_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;
   logic accept;
   assign accept = start && !busy;

   // stage 1: decode, unpack integer magnitude or widen f16
   ctrl_type c1_ff, c1_in;
   logic v1_ff;
   logic [31:0] d1_ff, d1_in;   // copy value, f32 value or magnitude
   logic int1_ff, int1_in;      // d1 holds an integer magnitude
   logic neg1_ff, neg1_in;
   logic [15:0] h;
   logic [4:0] hex;
   logic [9:0] hman;
   logic [4:0] hsh;
   logic [12:0] hnorm;
   logic [31:0] iv;

   always_comb begin
      c1_in.dst = dst_ff;
      d1_in = 32'd0;
      int1_in = 1'b0;
      neg1_in = 1'b0;
      h = req_raw_element[15:0];
      hex = h[14:10];
      hman = h[9:0];
      hsh = 5'd0;
      hnorm = 13'd0;
      iv = req_raw_element & width_mask(src_ff);
      if (src_ff > TYPE_I8 || dst_ff > TYPE_I8) c1_in.op = OP_ERROR;
      else if (src_ff == dst_ff) begin
         c1_in.op = OP_COPY;
         d1_in = iv;
      end else if (dst_ff == TYPE_F16) c1_in.op = OP_ERROR;
      else begin
         c1_in.op = (dst_ff == TYPE_F32) ? OP_TO_F32 : OP_TO_INT;
         case (src_ff)
            TYPE_F32: d1_in = req_raw_element;
            TYPE_F16: begin
               if (hex == 5'd0) begin
                  if (hman == 10'd0) d1_in = {h[15], 31'd0};
                  else begin
                     hsh = 5'd10 - lead_one({22'd0, hman});
                     hnorm = {3'd0, hman} << hsh;
                     d1_in = {h[15], 8'(8'd113 - {3'd0, hsh}), hnorm[9:0], 13'd0};
                  end
               end else if (hex == 5'd31) d1_in = {h[15], 8'hFF, hman, 13'd0};
               else d1_in = {h[15], 8'({3'd0, hex} + 8'd112), hman, 13'd0};
            end
            default: begin
               int1_in = 1'b1;
               case (src_ff)
                  TYPE_I8: neg1_in = iv[7];
                  TYPE_I16: neg1_in = iv[15];
                  default: neg1_in = iv[31];
               endcase
               d1_in = neg1_in ? ((32'd0 - iv) & width_mask(src_ff)) : iv;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= accept;
      c1_ff <= c1_in;
      d1_ff <= d1_in;
      int1_ff <= int1_in;
      neg1_ff <= neg1_in;
   end

   // stage 2: leading one and alignment of the integer magnitude
   ctrl_type c2_ff;
   logic v2_ff, int2_ff, neg2_ff, zero2_ff, zero2_in;
   logic [31:0] d2_ff, d2_in;   // integer magnitude shifted so leading one is at bit 31, else d1 as is
   logic [4:0] p2_ff, p2_in;
   always_comb begin
      zero2_in = (d1_ff == 32'd0);
      p2_in = lead_one(d1_ff);
      d2_in = int1_ff ? (d1_ff << (5'd31 - p2_in)) : d1_ff;
   end
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      c2_ff <= c1_ff;
      int2_ff <= int1_ff;
      neg2_ff <= neg1_ff;
      zero2_ff <= zero2_in;
      d2_ff <= d2_in;
      p2_ff <= p2_in;
   end

   // stage 3: round to nearest even, build binary32
   ctrl_type c3_ff;
   logic v3_ff;
   logic [31:0] d3_ff, d3_in;
   logic [24:0] sig;
   logic [7:0] e;
   logic rnd;
   always_comb begin
      // 24 kept bits, guard at bit 7, sticky below
      rnd = d2_ff[7] && ((d2_ff[6:0] != 7'd0) || d2_ff[8]);
      sig = {1'b0, d2_ff[31:8]} + {24'd0, rnd};
      e = 8'd127 + {3'd0, p2_ff};
      if (sig[24]) begin
         sig = sig >> 1;
         e = e + 8'd1;
      end
      if (!int2_ff) d3_in = d2_ff;
      else if (zero2_ff) d3_in = 32'd0;
      else d3_in = {neg2_ff, e, sig[22:0]};
   end
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      c3_ff <= c2_ff;
      d3_ff <= d3_in;
   end

   // stage 4: integer conversion, other ops pass alongside
   logic v4;
   logic [31:0] iout;
   logic [StatusWidth-1:0] istat;
   tdc_to_int u_to_int (
      .clock(clock), .reset(reset), .in_valid(v3_ff), .in_f(d3_ff),
      .in_dst(c3_ff.dst), .out_valid(v4), .out_value(iout), .out_status(istat)
   );
   logic [1:0] op4_ff;
   logic [31:0] d4_ff;
   always_ff @(posedge clock) begin
      op4_ff <= c3_ff.op;
      d4_ff <= d3_ff;
   end

   always_comb begin
      case (op4_ff)
         OP_TO_INT: begin
            rsp_converted_element = iout;
            rsp_status = istat;
         end
         OP_ERROR: begin
            rsp_converted_element = 32'd0;
            rsp_status = STATUS_UNSUPPORTED;
         end
         default: begin
            rsp_converted_element = d4_ff;
            rsp_status = STATUS_OK;
         end
      endcase
   end
   assign rsp_valid = v4;

`ifndef NO_ASSERTIONS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##3 rsp_valid) else $error("response lost in pipeline");
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(v3_ff)) else $error("spurious response");
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_UNSUPPORTED) |-> rsp_converted_element == 32'd0)
      else $error("unsupported pair gave data");
`endif
endmodule
`default_nettype wire
